// ===== src/cowpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cowpm_pkg
// Shared types and constants of the copy-on-write page mapper.
// ----------------------------------------------------------------------------
package cowpm_pkg;

    localparam int PAGE_BITS     = 12;
    localparam int MAP_BITS      = 12;
    localparam int PAGE_BYTES    = 1 << PAGE_BITS;
    localparam int MAP_PAGES     = 1 << MAP_BITS;
    localparam int MAX_REQ_PAGES = 32;

    localparam int ADDR_W = PAGE_BITS + MAP_BITS;
    localparam int SUM_W  = ADDR_W + 1;
    localparam int LEN_W  = 18;
    localparam int ROFF_W = 17;
    localparam int SLOT_W = MAP_BITS;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] MAX_REQ_BYTES = LEN_W'(MAX_REQ_PAGES * PAGE_BYTES);
    localparam logic [SUM_W-1:0] EXPORT_BYTES  = SUM_W'(1) << ADDR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COW_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARSE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ALWAYS = 2'd2;

    typedef enum logic [1:0] {
        ACT_RAW    = 2'd0,
        ACT_DIFF   = 2'd1,
        ACT_COPY   = 2'd2,
        ACT_REJECT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SYNC_NONE = 2'd0,
        SYNC_FULL = 2'd1,
        SYNC_DATA = 2'd2
    } sync_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_CHECK = 2'd2,
        ST_RUN   = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_PAGE   = 2'd1,
        OP_RAW    = 2'd2,
        OP_REJECT = 2'd3
    } op_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } map_entry_t;

    localparam int ENTRY_W = $bits(map_entry_t);

    typedef struct packed {
        logic                en;
        logic [MAP_BITS-1:0] addr;
    } map_rd_t;

    typedef struct packed {
        logic                en;
        logic [MAP_BITS-1:0] addr;
        map_entry_t          data;
    } map_wr_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] pos;
        logic [ROFF_W-1:0] roff;
        logic [LEN_W-1:0]  clen;
        sync_t             sk;
        logic              last;
    } stage_t;

endpackage

// ===== src/cowpm_map_ram.sv =====
// ----------------------------------------------------------------------------
// cowpm_map_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cowpm_map_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 13
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/cowpm_split.sv =====
// ----------------------------------------------------------------------------
// cowpm_split
// Request sequencer: map clearing pass, request checks, page splitting and
// map read issue.
// ----------------------------------------------------------------------------
module cowpm_split (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cowpm_pkg::ADDR_W-1:0] byte_addr,
    input  logic [cowpm_pkg::LEN_W-1:0]  byte_len,
    input  logic                         force_unit_access,
    input  logic                         cow_enable,
    input  logic                         sync_always,
    output cowpm_pkg::map_rd_t           rd,
    output cowpm_pkg::map_wr_t           clr,
    output cowpm_pkg::stage_t            s2
);

    cowpm_pkg::state_t                 state_reg, state_next;
    logic [cowpm_pkg::ADDR_W-1:0]      pos_reg, pos_next;
    logic [cowpm_pkg::LEN_W-1:0]       done_reg, done_next;
    logic [cowpm_pkg::LEN_W-1:0]       len_reg, len_next;
    cowpm_pkg::sync_t                  sk_reg, sk_next;
    logic [cowpm_pkg::MAP_BITS-1:0]    clr_cnt_reg, clr_cnt_next;
    cowpm_pkg::stage_t                 s2_reg, s2_next;

    logic [cowpm_pkg::PAGE_BITS-1:0]   off;
    logic [cowpm_pkg::PAGE_BITS:0]     room;
    logic [cowpm_pkg::LEN_W-1:0]       rest;
    logic [cowpm_pkg::LEN_W-1:0]       chunk;
    logic                              fin;
    logic [cowpm_pkg::SUM_W-1:0]       end_addr;
    logic                              reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cowpm_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            s2_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            s2_reg      <= s2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        done_reg <= done_next;
        len_reg  <= len_next;
        sk_reg   <= sk_next;
    end

    always_comb
    begin
        off      = pos_reg[cowpm_pkg::PAGE_BITS-1:0];
        room     = (cowpm_pkg::PAGE_BITS+1)'(cowpm_pkg::PAGE_BYTES) - {1'b0, off};
        rest     = len_reg - done_reg;
        chunk    = (rest < cowpm_pkg::LEN_W'(room)) ? rest : cowpm_pkg::LEN_W'(room);
        fin      = (chunk == rest);
        end_addr = {1'b0, pos_reg} + cowpm_pkg::SUM_W'(len_reg);
        reject   = (len_reg == '0) || (len_reg > cowpm_pkg::MAX_REQ_BYTES) ||
                   (end_addr > cowpm_pkg::EXPORT_BYTES);
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        done_next    = done_reg;
        len_next     = len_reg;
        sk_next      = sk_reg;
        clr_cnt_next = clr_cnt_reg;
        s2_next      = '0;
        busy         = 1'b1;
        rd.en        = 1'b0;
        rd.addr      = pos_reg[cowpm_pkg::ADDR_W-1:cowpm_pkg::PAGE_BITS];
        clr.en       = 1'b0;
        clr.addr     = clr_cnt_reg;
        clr.data     = '0;

        unique case (state_reg)
            cowpm_pkg::ST_CLEAR:
            begin
                clr.en       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = cowpm_pkg::ST_IDLE;
                end
            end
            cowpm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    pos_next   = byte_addr;
                    len_next   = byte_len;
                    done_next  = '0;
                    sk_next    = sync_always ? cowpm_pkg::SYNC_FULL :
                                 (force_unit_access ? cowpm_pkg::SYNC_DATA :
                                  cowpm_pkg::SYNC_NONE);
                    state_next = cowpm_pkg::ST_CHECK;
                end
            end
            cowpm_pkg::ST_CHECK:
            begin
                if (reject)
                begin
                    s2_next.op   = cowpm_pkg::OP_REJECT;
                    s2_next.sk   = cowpm_pkg::SYNC_NONE;
                    s2_next.last = 1'b1;
                    state_next   = cowpm_pkg::ST_IDLE;
                end
                else if (!cow_enable)
                begin
                    s2_next.op   = cowpm_pkg::OP_RAW;
                    s2_next.pos  = pos_reg;
                    s2_next.clen = len_reg;
                    s2_next.sk   = sk_reg;
                    s2_next.last = 1'b1;
                    state_next   = cowpm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = cowpm_pkg::ST_RUN;
                end
            end
            cowpm_pkg::ST_RUN:
            begin
                rd.en        = 1'b1;
                s2_next.op   = cowpm_pkg::OP_PAGE;
                s2_next.pos  = pos_reg;
                s2_next.roff = done_reg[cowpm_pkg::ROFF_W-1:0];
                s2_next.clen = chunk;
                s2_next.sk   = fin ? sk_reg : cowpm_pkg::SYNC_NONE;
                s2_next.last = fin;
                pos_next     = pos_reg + cowpm_pkg::ADDR_W'(chunk);
                done_next    = done_reg + chunk;
                if (fin)
                begin
                    state_next = cowpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cowpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign s2 = s2_reg;

    a_read_feeds_page: assert property (@(posedge clk) disable iff (!rst_n)
        rd.en |=> s2_reg.op == cowpm_pkg::OP_PAGE)
        else $error("map read without page stage");

    a_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.op == cowpm_pkg::OP_PAGE |-> s2_reg.clen != '0)
        else $error("empty page chunk");

    a_chunk_to_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.op == cowpm_pkg::OP_PAGE && !s2_reg.last) |->
        ({1'b0, s2_reg.pos[cowpm_pkg::PAGE_BITS-1:0]} +
         s2_reg.clen[cowpm_pkg::PAGE_BITS:0]) ==
        (cowpm_pkg::PAGE_BITS+1)'(cowpm_pkg::PAGE_BYTES))
        else $error("inner chunk does not end at page boundary");

endmodule

// ===== src/cowpm_resolve.sv =====
// ----------------------------------------------------------------------------
// cowpm_resolve
// Map entry resolution: page allocation, map write-back and result register.
// ----------------------------------------------------------------------------
module cowpm_resolve (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sparse_mode,
    input  cowpm_pkg::stage_t             s2,
    input  cowpm_pkg::map_entry_t         rdata,
    output cowpm_pkg::map_wr_t            wr,
    output logic                          strobe,
    output logic [1:0]                    action,
    output logic [cowpm_pkg::ROFF_W-1:0]  request_offset,
    output logic [cowpm_pkg::LEN_W-1:0]   chunk_len,
    output logic [cowpm_pkg::ADDR_W-1:0]  export_offset,
    output logic [cowpm_pkg::ADDR_W-1:0]  diff_offset,
    output logic [cowpm_pkg::PAGE_BITS-1:0] page_offset,
    output logic [1:0]                    sync_kind,
    output logic                          last
);

    logic [cowpm_pkg::SLOT_W-1:0]    used_reg, used_next;
    logic                            strobe_reg, strobe_next;
    cowpm_pkg::action_t              action_reg, action_next;
    logic [cowpm_pkg::ROFF_W-1:0]    roff_reg, roff_next;
    logic [cowpm_pkg::LEN_W-1:0]     clen_reg, clen_next;
    logic [cowpm_pkg::ADDR_W-1:0]    eoff_reg, eoff_next;
    logic [cowpm_pkg::ADDR_W-1:0]    doff_reg, doff_next;
    logic [cowpm_pkg::PAGE_BITS-1:0] poff_reg, poff_next;
    cowpm_pkg::sync_t                sk_reg, sk_next;
    logic                            last_reg, last_next;

    logic [cowpm_pkg::MAP_BITS-1:0]  page;
    logic [cowpm_pkg::PAGE_BITS-1:0] off;
    logic [cowpm_pkg::SLOT_W-1:0]    slot_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        roff_reg   <= roff_next;
        clen_reg   <= clen_next;
        eoff_reg   <= eoff_next;
        doff_reg   <= doff_next;
        poff_reg   <= poff_next;
        sk_reg     <= sk_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        page        = s2.pos[cowpm_pkg::ADDR_W-1:cowpm_pkg::PAGE_BITS];
        off         = s2.pos[cowpm_pkg::PAGE_BITS-1:0];
        slot_new    = sparse_mode ? page : used_reg;
        used_next   = used_reg;
        wr.en       = 1'b0;
        wr.addr     = page;
        wr.data     = '{valid: 1'b1, slot: slot_new};
        strobe_next = (s2.op != cowpm_pkg::OP_NONE);
        action_next = action_reg;
        roff_next   = roff_reg;
        clen_next   = clen_reg;
        eoff_next   = eoff_reg;
        doff_next   = doff_reg;
        poff_next   = poff_reg;
        sk_next     = sk_reg;
        last_next   = last_reg;

        unique case (s2.op)
            cowpm_pkg::OP_NONE:
            begin
            end
            cowpm_pkg::OP_PAGE:
            begin
                roff_next = s2.roff;
                clen_next = s2.clen;
                poff_next = off;
                sk_next   = s2.sk;
                last_next = s2.last;
                if (rdata.valid)
                begin
                    action_next = cowpm_pkg::ACT_DIFF;
                    eoff_next   = '0;
                    doff_next   = {rdata.slot, off};
                end
                else
                begin
                    wr.en       = 1'b1;
                    action_next = cowpm_pkg::ACT_COPY;
                    eoff_next   = {page, {cowpm_pkg::PAGE_BITS{1'b0}}};
                    doff_next   = {slot_new, {cowpm_pkg::PAGE_BITS{1'b0}}};
                    if (!sparse_mode)
                    begin
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            cowpm_pkg::OP_RAW:
            begin
                action_next = cowpm_pkg::ACT_RAW;
                roff_next   = '0;
                clen_next   = s2.clen;
                eoff_next   = s2.pos;
                doff_next   = '0;
                poff_next   = '0;
                sk_next     = s2.sk;
                last_next   = 1'b1;
            end
            cowpm_pkg::OP_REJECT:
            begin
                action_next = cowpm_pkg::ACT_REJECT;
                roff_next   = '0;
                clen_next   = '0;
                eoff_next   = '0;
                doff_next   = '0;
                poff_next   = '0;
                sk_next     = cowpm_pkg::SYNC_NONE;
                last_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign strobe         = strobe_reg;
    assign action         = action_reg;
    assign request_offset = roff_reg;
    assign chunk_len      = clen_reg;
    assign export_offset  = eoff_reg;
    assign diff_offset    = doff_reg;
    assign page_offset    = poff_reg;
    assign sync_kind      = sk_reg;
    assign last           = last_reg;

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && action_reg == cowpm_pkg::ACT_REJECT) |-> last_reg)
        else $error("rejection not marked last");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |=> !strobe_reg)
        else $error("result right after final transaction");

endmodule

// ===== src/copy_on_write_page_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// copy_on_write_page_mapper_unit
// Splits write requests at page boundaries and redirects them through a
// copy-on-write page map; with cow_enable low they pass through unsplit.
// ----------------------------------------------------------------------------
// A request transaction is taken when start is high and busy is low. Each
// command comes out on the result ports for one cycle with strobe high; the
// final command of a request carries last. The receiver cannot stall.
// Configuration: cfg_we, cfg_index and cfg_data write cow_enable (0),
// sparse_mode (1) and sync_always (2); the user must write them only while
// busy is low, which the block does not enforce. A rejected request or a
// raw write gives one result via the check state, stage register and result
// register; busy is high for one cycle after acceptance. In copy-on-write
// mode a request spanning N pages (N up to 33) keeps busy high through the
// check and run states, one page map read-modify-write per cycle through the
// map RAM; the first command passes the check and run states and the result
// register, then one per cycle. The next request can be taken in the cycle
// busy drops. After reset, busy stays high while all 4096 page map entries
// are cleared, one entry per cycle; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module copy_on_write_page_mapper_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cowpm_pkg::ADDR_W-1:0]    byte_addr,
    input  logic [cowpm_pkg::LEN_W-1:0]     byte_len,
    input  logic                            force_unit_access,
    input  logic                            cfg_we,
    input  logic [cowpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                            cfg_data,
    output logic                            strobe,
    output logic [1:0]                      action,
    output logic [cowpm_pkg::ROFF_W-1:0]    request_offset,
    output logic [cowpm_pkg::LEN_W-1:0]     chunk_len,
    output logic [cowpm_pkg::ADDR_W-1:0]    export_offset,
    output logic [cowpm_pkg::ADDR_W-1:0]    diff_offset,
    output logic [cowpm_pkg::PAGE_BITS-1:0] page_offset,
    output logic [1:0]                      sync_kind,
    output logic                            last
);

    logic                  cow_enable_reg;
    logic                  sparse_mode_reg;
    logic                  sync_always_reg;

    cowpm_pkg::map_rd_t    rd;
    cowpm_pkg::map_wr_t    clr;
    cowpm_pkg::map_wr_t    wr;
    cowpm_pkg::stage_t     s2;
    cowpm_pkg::map_entry_t rdata;

    logic                               ram_we;
    logic [cowpm_pkg::MAP_BITS-1:0]     ram_waddr;
    logic [cowpm_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [cowpm_pkg::ENTRY_W-1:0]      ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cow_enable_reg  <= 1'b0;
            sparse_mode_reg <= 1'b0;
            sync_always_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cowpm_pkg::CFG_COW_ENABLE)
            begin
                cow_enable_reg <= cfg_data;
            end
            if (cfg_index == cowpm_pkg::CFG_SPARSE_MODE)
            begin
                sparse_mode_reg <= cfg_data;
            end
            if (cfg_index == cowpm_pkg::CFG_SYNC_ALWAYS)
            begin
                sync_always_reg <= cfg_data;
            end
        end
    end

    cowpm_split u_split (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .byte_addr         (byte_addr),
        .byte_len          (byte_len),
        .force_unit_access (force_unit_access),
        .cow_enable        (cow_enable_reg),
        .sync_always       (sync_always_reg),
        .rd                (rd),
        .clr               (clr),
        .s2                (s2)
    );

    assign ram_we    = clr.en | wr.en;
    assign ram_waddr = clr.en ? clr.addr : wr.addr;
    assign ram_wdata = clr.en ? clr.data : wr.data;
    assign rdata     = ram_rdata;

    cowpm_map_ram #(
        .ADDR_W (cowpm_pkg::MAP_BITS),
        .DATA_W (cowpm_pkg::ENTRY_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (ram_rdata)
    );

    cowpm_resolve u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .sparse_mode    (sparse_mode_reg),
        .s2             (s2),
        .rdata          (rdata),
        .wr             (wr),
        .strobe         (strobe),
        .action         (action),
        .request_offset (request_offset),
        .chunk_len      (chunk_len),
        .export_offset  (export_offset),
        .diff_offset    (diff_offset),
        .page_offset    (page_offset),
        .sync_kind      (sync_kind),
        .last           (last)
    );

endmodule

// ===== test/cowpm_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cowpm_checker
// Watches the request, configuration and result ports of the copy-on-write
// page mapper. Keeps its own page redirect map and register copies, and
// works out the commands each accepted request must give. Every result
// strobe is compared field by field with the oldest outstanding command.
// Reports a running failure count and the number of commands still due.
// ----------------------------------------------------------------------------
module cowpm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [cowpm_pkg::ADDR_W-1:0]    byte_addr,
    input  logic [cowpm_pkg::LEN_W-1:0]     byte_len,
    input  logic                            force_unit_access,
    input  logic                            cfg_we,
    input  logic [cowpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                            cfg_data,
    input  logic                            strobe,
    input  logic [1:0]                      action,
    input  logic [cowpm_pkg::ROFF_W-1:0]    request_offset,
    input  logic [cowpm_pkg::LEN_W-1:0]     chunk_len,
    input  logic [cowpm_pkg::ADDR_W-1:0]    export_offset,
    input  logic [cowpm_pkg::ADDR_W-1:0]    diff_offset,
    input  logic [cowpm_pkg::PAGE_BITS-1:0] page_offset,
    input  logic [1:0]                      sync_kind,
    input  logic                            last,
    output int                              errors,
    output int                              pending_cmds
);

    typedef struct packed {
        cowpm_pkg::action_t              act;
        logic [cowpm_pkg::ROFF_W-1:0]    roff;
        logic [cowpm_pkg::LEN_W-1:0]     clen;
        logic [cowpm_pkg::ADDR_W-1:0]    eoff;
        logic [cowpm_pkg::ADDR_W-1:0]    doff;
        logic [cowpm_pkg::PAGE_BITS-1:0] poff;
        cowpm_pkg::sync_t                sk;
        logic                            last;
    } page_cmd_t;

    page_cmd_t expected_cmds[$];
    bit        map_valid[cowpm_pkg::MAP_PAGES];
    longint    map_slot[cowpm_pkg::MAP_PAGES];
    longint    pages_appended;
    logic      cow_on;
    logic      sparse_on;
    logic      sync_on;
    int        fail_total;

    function automatic void add_cmd(input cowpm_pkg::action_t act, input longint roff,
                                    input longint clen, input longint eoff,
                                    input longint doff, input longint poff,
                                    input cowpm_pkg::sync_t sk, input logic fin);
        page_cmd_t c;
        c.act  = act;
        c.roff = cowpm_pkg::ROFF_W'(roff);
        c.clen = cowpm_pkg::LEN_W'(clen);
        c.eoff = cowpm_pkg::ADDR_W'(eoff);
        c.doff = cowpm_pkg::ADDR_W'(doff);
        c.poff = cowpm_pkg::PAGE_BITS'(poff);
        c.sk   = sk;
        c.last = fin;
        expected_cmds.push_back(c);
    endfunction

    function automatic void map_write_request(input logic [cowpm_pkg::ADDR_W-1:0] addr,
                                              input logic [cowpm_pkg::LEN_W-1:0] len,
                                              input logic fua);
        longint           pos;
        longint           done;
        longint           total;
        longint           page;
        longint           off;
        longint           chunk;
        longint           slot;
        cowpm_pkg::sync_t sk;
        cowpm_pkg::sync_t chunk_sk;
        logic             fin;
        total = longint'(len);
        sk = sync_on ? cowpm_pkg::SYNC_FULL :
             (fua ? cowpm_pkg::SYNC_DATA : cowpm_pkg::SYNC_NONE);
        if (total == 0 || total > longint'(cowpm_pkg::MAX_REQ_BYTES) ||
            longint'(addr) + total > longint'(cowpm_pkg::EXPORT_BYTES))
        begin
            add_cmd(cowpm_pkg::ACT_REJECT, 0, 0, 0, 0, 0, cowpm_pkg::SYNC_NONE, 1'b1);
            return;
        end
        if (!cow_on)
        begin
            add_cmd(cowpm_pkg::ACT_RAW, 0, total, longint'(addr), 0, 0, sk, 1'b1);
            return;
        end
        pos = longint'(addr);
        done = 0;
        while (done < total)
        begin
            page = pos / cowpm_pkg::PAGE_BYTES;
            off = pos % cowpm_pkg::PAGE_BYTES;
            chunk = total - done;
            if (chunk > cowpm_pkg::PAGE_BYTES - off)
                chunk = cowpm_pkg::PAGE_BYTES - off;
            fin = (done + chunk >= total);
            chunk_sk = fin ? sk : cowpm_pkg::SYNC_NONE;
            if (map_valid[page])
            begin
                add_cmd(cowpm_pkg::ACT_DIFF, done, chunk, 0,
                        map_slot[page] * cowpm_pkg::PAGE_BYTES + off,
                        off, chunk_sk, fin);
            end
            else
            begin
                if (sparse_on)
                begin
                    slot = page;
                end
                else
                begin
                    slot = pages_appended;
                    pages_appended++;
                end
                map_slot[page] = slot;
                map_valid[page] = 1'b1;
                add_cmd(cowpm_pkg::ACT_COPY, done, chunk, page * cowpm_pkg::PAGE_BYTES,
                        slot * cowpm_pkg::PAGE_BYTES, off, chunk_sk, fin);
            end
            done += chunk;
            pos += chunk;
        end
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        page_cmd_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < cowpm_pkg::MAP_PAGES; i++)
            begin
                map_valid[i] = 1'b0;
                map_slot[i] = 0;
            end
            pages_appended = 0;
            cow_on = 1'b0;
            sparse_on = 1'b0;
            sync_on = 1'b0;
            expected_cmds.delete();
            fail_total = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual action %0h",
                             $time, action);
                    fail_total++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("action", 32'(want.act), 32'(action));
                    check_field("request_offset", 32'(want.roff), 32'(request_offset));
                    check_field("chunk_len", 32'(want.clen), 32'(chunk_len));
                    check_field("export_offset", 32'(want.eoff), 32'(export_offset));
                    check_field("diff_offset", 32'(want.doff), 32'(diff_offset));
                    check_field("page_offset", 32'(want.poff), 32'(page_offset));
                    check_field("sync_kind", 32'(want.sk), 32'(sync_kind));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    cowpm_pkg::CFG_COW_ENABLE:  cow_on = cfg_data;
                    cowpm_pkg::CFG_SPARSE_MODE: sparse_on = cfg_data;
                    cowpm_pkg::CFG_SYNC_ALWAYS: sync_on = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                map_write_request(byte_addr, byte_len, force_unit_access);
        end
        errors <= fail_total;
        pending_cmds <= expected_cmds.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of copy_on_write_page_mapper_unit. Drives directed and random
// write requests through raw, append and sparse copy-on-write settings,
// with random idle bursts, and lets the checker compare every command.
// ----------------------------------------------------------------------------
module tb_top;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [cowpm_pkg::ADDR_W-1:0]    byte_addr = '0;
    logic [cowpm_pkg::LEN_W-1:0]     byte_len = '0;
    logic                            force_unit_access = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [cowpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic                            cfg_data = 1'b0;
    logic                            strobe;
    logic [1:0]                      action;
    logic [cowpm_pkg::ROFF_W-1:0]    request_offset;
    logic [cowpm_pkg::LEN_W-1:0]     chunk_len;
    logic [cowpm_pkg::ADDR_W-1:0]    export_offset;
    logic [cowpm_pkg::ADDR_W-1:0]    diff_offset;
    logic [cowpm_pkg::PAGE_BITS-1:0] page_offset;
    logic [1:0]                      sync_kind;
    logic                            last;
    int                              errors;
    int                              pending_cmds;

    always #2 clk = ~clk;

    copy_on_write_page_mapper_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .byte_addr         (byte_addr),
        .byte_len          (byte_len),
        .force_unit_access (force_unit_access),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .strobe            (strobe),
        .action            (action),
        .request_offset    (request_offset),
        .chunk_len         (chunk_len),
        .export_offset     (export_offset),
        .diff_offset       (diff_offset),
        .page_offset       (page_offset),
        .sync_kind         (sync_kind),
        .last              (last)
    );

    cowpm_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .byte_addr         (byte_addr),
        .byte_len          (byte_len),
        .force_unit_access (force_unit_access),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .strobe            (strobe),
        .action            (action),
        .request_offset    (request_offset),
        .chunk_len         (chunk_len),
        .export_offset     (export_offset),
        .diff_offset       (diff_offset),
        .page_offset       (page_offset),
        .sync_kind         (sync_kind),
        .last              (last),
        .errors            (errors),
        .pending_cmds      (pending_cmds)
    );

    task automatic send_request(input logic [cowpm_pkg::ADDR_W-1:0] addr,
                                input logic [cowpm_pkg::LEN_W-1:0] len,
                                input logic fua);
        start <= 1'b1;
        byte_addr <= addr;
        byte_len <= len;
        force_unit_access <= fua;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_cmds != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mode(input logic cow, input logic sparse, input logic sync_all);
        cfg_we <= 1'b1;
        cfg_index <= cowpm_pkg::CFG_COW_ENABLE;
        cfg_data <= cow;
        @(posedge clk);
        cfg_index <= cowpm_pkg::CFG_SPARSE_MODE;
        cfg_data <= sparse;
        @(posedge clk);
        cfg_index <= cowpm_pkg::CFG_SYNC_ALWAYS;
        cfg_data <= sync_all;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("** copy_on_write_page_mapper_unit: FAILED **");
        $finish;
    end

    initial
    begin
        logic [cowpm_pkg::ADDR_W-1:0] a;
        logic [cowpm_pkg::LEN_W-1:0]  l;
        int                           kind;
        int                           r;
        int                           hot_page;
        hot_page = $urandom_range(0, cowpm_pkg::MAP_PAGES - 64 - 40);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // raw export writes and rejections
        set_mode(1'b0, 1'b0, 1'b0);
        send_request(24'h000000, 18'd1, 1'b0);
        send_request(24'hFFFFFF, 18'd1, 1'b1);
        send_request(24'hFFFFFF, 18'd2, 1'b0);
        send_request(24'h000000, 18'd0, 1'b0);
        send_request(24'h000000, 18'd131072, 1'b1);
        send_request(24'h000000, 18'd131073, 1'b0);
        send_request(24'h123456, 18'h3FFFF, 1'b1);
        drain();
        set_mode(1'b0, 1'b0, 1'b1);
        send_request(24'h800000, 18'd100, 1'b0);
        send_request(24'h800000, 18'd100, 1'b1);
        drain();

        // append allocation, page splits, in-place hits
        set_mode(1'b1, 1'b0, 1'b0);
        send_request(24'h000FFF, 18'd2, 1'b1);
        send_request(24'h000000, 18'd4096, 1'b0);
        send_request(24'h001000, 18'd131072, 1'b0);
        send_request(24'h002800, 18'd131072, 1'b1);
        send_request(24'hFFF000, 18'd4096, 1'b1);
        send_request(24'hFFFFFF, 18'd1, 1'b0);
        send_request(24'hFFFFF0, 18'd32, 1'b0);
        send_request(24'h000005, 18'd0, 1'b1);
        drain();

        // sparse allocation and in-place hits
        set_mode(1'b1, 1'b1, 1'b1);
        send_request(24'h400000, 18'd8192, 1'b0);
        send_request(24'h030000, 18'd10, 1'b1);
        send_request(24'h400010, 18'd4000, 1'b0);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            case (ph)
                0: set_mode(1'b1, 1'b0, 1'b0);
                1: set_mode(1'b1, 1'b1, 1'b0);
                default: set_mode($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
            endcase
            for (int i = 0; i < 20; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    a = cowpm_pkg::ADDR_W'((hot_page + $urandom_range(0, 63)) *
                                           cowpm_pkg::PAGE_BYTES +
                                           $urandom_range(0, cowpm_pkg::PAGE_BYTES - 1));
                    r = $urandom_range(0, 9);
                    if (r < 6)
                        l = cowpm_pkg::LEN_W'($urandom_range(1, 8192));
                    else if (r < 9)
                        l = cowpm_pkg::LEN_W'($urandom_range(1, 16384));
                    else
                        l = cowpm_pkg::LEN_W'($urandom_range(1, 131072));
                end
                else if (kind < 85)
                begin
                    a = cowpm_pkg::ADDR_W'($urandom);
                    l = cowpm_pkg::LEN_W'($urandom_range(1, 131072));
                end
                else
                begin
                    a = cowpm_pkg::ADDR_W'($urandom);
                    l = ($urandom_range(0, 3) == 0) ? '0 : cowpm_pkg::LEN_W'($urandom);
                end
                send_request(a, l, 1'($urandom_range(0, 1)));
                if (ph < 4 && $urandom_range(0, 9) < 3)
                    pause_cycles($urandom_range(1, 7));
            end
        end
        drain();

        if (errors == 0)
            $display("** copy_on_write_page_mapper_unit: PASSED **");
        else
            $display("** copy_on_write_page_mapper_unit: FAILED **");
        $finish;
    end

endmodule
